[rtl/idab_pkg.sv]
// shared types and constants for the two-bitmap id allocator
// no dependencies; used by idab_map and id_allocator_two_bitmap_unit
package idab_pkg;

  localparam int ID_W      = 8;
  localparam int OP_W      = 3;
  localparam int CNT_W     = 9;
  localparam int CFG_IDX_W = 1;

  localparam int unsigned DEF_ID_SPACE = 256;

  localparam logic [ID_W-1:0] MIN_ID_RST = 8'd1;
  localparam logic [ID_W-1:0] MAX_ID_RST = 8'd255;

  typedef enum logic [OP_W-1:0] {
    OP_TAKE    = 3'd0,
    OP_RELEASE = 3'd1,
    OP_RESERVE = 3'd2,
    OP_MARK    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_ID = 1'b0,
    CFG_MAX_ID = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

  // one map entry: both bitmaps side by side
  typedef struct packed {
    logic ever;
    logic in_use;
  } entry_t;

endpackage

[rtl/idab_map.sv]
// bitmap store: one entry per id holding the ever-used and in-use bits
// one write port, one registered read port, per-entry valid flags for clear
// depends on idab_pkg
module idab_map #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  idab_pkg::entry_t     wr_data,
  input  logic [AW-1:0]        rd_addr,
  output idab_pkg::entry_t     rd_data
);

  idab_pkg::entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  idab_pkg::entry_t rd_q_r;
  logic             rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // an entry never written since reset or clear reads as empty
  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule

[rtl/id_allocator_two_bitmap_unit.sv]
// round-robin id allocator with ever-used and in-use bitmaps
// depends on idab_pkg and idab_map
//
// Commands enter on start while busy is low; every command gives exactly one
// result, shown for a single cycle with out_valid high, and the receiver must
// take it then since it cannot stall the block. Clear, unused op codes, a take
// on an empty range and commands on an out-of-range id finish at once: the
// result appears the cycle after start. Release, reserve and mark used read the
// id's map entry and write it back, so busy is high for one cycle, the update
// state, and the result is registered from it. A take scans the id range from
// the rotating pointer, reading one map entry per cycle through the single
// bitmap read port; it stops early on the first never-used id and otherwise
// sweeps the whole range and takes the first id not in use. A take keeps busy
// high through the scan and, if it finds an id, the commit state; the result
// shows in the same cycle that busy drops. Clear empties both bitmaps at once
// through the map's valid flags, no sweep needed; there is no clearing pass
// after reset. min_id and max_id must be written through the cfg port only
// while no command is in flight; the block itself does not enforce this.
module id_allocator_two_bitmap_unit #(
  parameter int unsigned ID_SPACE = idab_pkg::DEF_ID_SPACE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  logic [idab_pkg::OP_W-1:0]     in_op,
  input  logic [idab_pkg::ID_W-1:0]     in_id,
  // result channel
  output logic                          out_valid,
  output logic [idab_pkg::ID_W-1:0]     out_given_id,
  output logic                          out_ok,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [idab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [idab_pkg::ID_W-1:0]     cfg_wdata
);

  // ids are 8 bits wide, so no more than 256 map entries are ever reachable
  localparam int unsigned ID_LIMIT  = 1 << idab_pkg::ID_W;
  localparam int unsigned MAP_DEPTH = (ID_SPACE < ID_LIMIT) ? ID_SPACE : ID_LIMIT;
  localparam int unsigned MAP_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

  localparam int ID_W  = idab_pkg::ID_W;
  localparam int CNT_W = idab_pkg::CNT_W;

  // id below the parameterized id space
  function automatic logic in_space(input logic [ID_W-1:0] v);
    in_space = (32'(v) < ID_SPACE);
  endfunction

  // control state
  idab_pkg::state_t    state_r, state_nxt;
  logic [ID_W-1:0]     min_r, max_r;
  logic [ID_W-1:0]     scan_start_r, scan_start_nxt;
  logic [CNT_W-1:0]    ever_cnt_r, ever_cnt_nxt;
  logic [CNT_W-1:0]    use_cnt_r, use_cnt_nxt;
  logic                q_vld_r, q_vld_nxt;
  logic                found_free_r, found_free_nxt;
  logic                out_valid_r, out_valid_nxt;

  // payload state
  idab_pkg::op_t       op_r, op_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [ID_W-1:0]     p_r, p_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    span_r, span_nxt;
  logic [ID_W-1:0]     q_addr_r, q_addr_nxt;
  logic [ID_W-1:0]     free_id_r, free_id_nxt;
  idab_pkg::entry_t    free_ent_r, free_ent_nxt;
  logic [ID_W-1:0]     tgt_r, tgt_nxt;
  idab_pkg::entry_t    tgt_ent_r, tgt_ent_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic                out_ok_r, out_ok_nxt;

  // map port
  logic                map_clr;
  logic                map_we;
  logic [ID_W-1:0]     map_waddr;
  idab_pkg::entry_t    map_wdata;
  logic [ID_W-1:0]     map_raddr;
  idab_pkg::entry_t    rd_ent;

  // decode helpers
  logic                acc;
  idab_pkg::op_t       in_op_e;
  logic                range_empty;
  logic                in_id_ok;
  logic [CNT_W-1:0]    span_w;
  logic [ID_W-1:0]     start_ptr;
  logic [ID_W-1:0]     p_wrap;
  logic                q_elig, q_new, q_free;
  logic                issue, scan_done;

  assign acc         = start && (state_r == idab_pkg::ST_IDLE);
  assign busy        = (state_r != idab_pkg::ST_IDLE);
  assign in_op_e     = idab_pkg::op_t'(in_op);
  assign range_empty = (max_r < min_r);
  assign in_id_ok    = (in_id >= min_r) && (in_id <= max_r) && in_space(in_id);
  assign span_w      = {1'b0, max_r} - {1'b0, min_r} + CNT_W'(1);
  // a pointer left outside a changed range restarts at min_id
  assign start_ptr   = ((scan_start_r < min_r) || (scan_start_r > max_r)) ? min_r
                                                                          : scan_start_r;
  assign p_wrap      = (p_r >= max_r) ? min_r : (p_r + ID_W'(1));

  // scan pipeline: data for q_addr_r comes back in the cycle after the read
  assign q_elig    = q_vld_r && in_space(q_addr_r);
  assign q_new     = q_elig && !rd_ent.ever;
  assign q_free    = q_elig && !rd_ent.in_use;
  assign issue     = (state_r == idab_pkg::ST_SCAN) && (cnt_r != span_r) && !q_new;
  assign scan_done = (state_r == idab_pkg::ST_SCAN) && (cnt_r == span_r) && !q_vld_r;

  // read the command's id on the accept edge, scan addresses otherwise
  assign map_raddr = (state_r == idab_pkg::ST_IDLE) ? in_id : p_r;

  idab_map #(
    .DEPTH (MAP_DEPTH),
    .AW    (MAP_AW)
  ) u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (map_clr),
    .wr_en   (map_we),
    .wr_addr (map_waddr[MAP_AW-1:0]),
    .wr_data (map_wdata),
    .rd_addr (map_raddr[MAP_AW-1:0]),
    .rd_data (rd_ent)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      idab_pkg::ST_IDLE: begin
        if (acc) begin
          unique case (in_op_e)
            idab_pkg::OP_TAKE: begin
              if (!range_empty) begin
                state_nxt = idab_pkg::ST_SCAN;
              end
            end
            idab_pkg::OP_RELEASE,
            idab_pkg::OP_RESERVE,
            idab_pkg::OP_MARK: begin
              if (in_id_ok) begin
                state_nxt = idab_pkg::ST_UPDATE;
              end
            end
            default: state_nxt = idab_pkg::ST_IDLE;
          endcase
        end
      end
      idab_pkg::ST_UPDATE: state_nxt = idab_pkg::ST_IDLE;
      idab_pkg::ST_SCAN: begin
        if (q_new) begin
          state_nxt = idab_pkg::ST_COMMIT;
        end else if (scan_done) begin
          state_nxt = found_free_r ? idab_pkg::ST_COMMIT : idab_pkg::ST_IDLE;
        end
      end
      idab_pkg::ST_COMMIT: state_nxt = idab_pkg::ST_IDLE;
      default: state_nxt = idab_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    scan_start_nxt = scan_start_r;
    ever_cnt_nxt   = ever_cnt_r;
    use_cnt_nxt    = use_cnt_r;
    q_vld_nxt      = 1'b0;
    found_free_nxt = found_free_r;
    op_nxt         = op_r;
    id_nxt         = id_r;
    p_nxt          = p_r;
    cnt_nxt        = cnt_r;
    span_nxt       = span_r;
    q_addr_nxt     = q_addr_r;
    free_id_nxt    = free_id_r;
    free_ent_nxt   = free_ent_r;
    tgt_nxt        = tgt_r;
    tgt_ent_nxt    = tgt_ent_r;
    out_valid_nxt  = 1'b0;
    out_id_nxt     = '0;
    out_ok_nxt     = 1'b0;
    map_clr        = 1'b0;
    map_we         = 1'b0;
    map_waddr      = id_r;
    map_wdata      = '0;

    unique case (state_r)
      idab_pkg::ST_IDLE: begin
        if (acc) begin
          op_nxt = in_op_e;
          id_nxt = in_id;
          unique case (in_op_e)
            idab_pkg::OP_TAKE: begin
              if (range_empty) begin
                out_valid_nxt = 1'b1;
              end else begin
                scan_start_nxt = start_ptr;
                p_nxt          = start_ptr;
                cnt_nxt        = '0;
                span_nxt       = span_w;
                found_free_nxt = 1'b0;
              end
            end
            idab_pkg::OP_RELEASE,
            idab_pkg::OP_RESERVE,
            idab_pkg::OP_MARK: begin
              // in-range ids finish in the update state
              if (!in_id_ok) begin
                out_valid_nxt = 1'b1;
              end
            end
            idab_pkg::OP_CLEAR: begin
              map_clr        = 1'b1;
              ever_cnt_nxt   = '0;
              use_cnt_nxt    = '0;
              scan_start_nxt = min_r;
              out_valid_nxt  = 1'b1;
              out_ok_nxt     = 1'b1;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      idab_pkg::ST_UPDATE: begin
        // rd_ent holds the entry of id_r, read on the accept edge
        map_we        = 1'b1;
        map_waddr     = id_r;
        out_valid_nxt = 1'b1;
        out_ok_nxt    = 1'b1;
        unique case (op_r)
          idab_pkg::OP_RELEASE: begin
            map_wdata = '{ever: rd_ent.ever, in_use: 1'b0};
            if (rd_ent.in_use) begin
              use_cnt_nxt = use_cnt_r - CNT_W'(1);
            end
          end
          idab_pkg::OP_RESERVE: begin
            map_wdata = '{ever: 1'b1, in_use: 1'b1};
            if (!rd_ent.in_use) begin
              use_cnt_nxt = use_cnt_r + CNT_W'(1);
            end
            if (!rd_ent.ever) begin
              ever_cnt_nxt = ever_cnt_r + CNT_W'(1);
            end
          end
          default: begin
            // mark used
            map_wdata = '{ever: 1'b1, in_use: rd_ent.in_use};
            if (!rd_ent.ever) begin
              ever_cnt_nxt = ever_cnt_r + CNT_W'(1);
            end
          end
        endcase
      end

      idab_pkg::ST_SCAN: begin
        if (issue) begin
          p_nxt      = p_wrap;
          cnt_nxt    = cnt_r + CNT_W'(1);
          q_vld_nxt  = 1'b1;
          q_addr_nxt = p_r;
        end
        // remember the first id not in use as the fallback
        if (q_free && !found_free_r) begin
          found_free_nxt = 1'b1;
          free_id_nxt    = q_addr_r;
          free_ent_nxt   = rd_ent;
        end
        if (q_new) begin
          tgt_nxt     = q_addr_r;
          tgt_ent_nxt = rd_ent;
        end else if (scan_done) begin
          if (found_free_r) begin
            tgt_nxt     = free_id_r;
            tgt_ent_nxt = free_ent_r;
          end else begin
            // nothing free
            out_valid_nxt = 1'b1;
          end
        end
      end

      idab_pkg::ST_COMMIT: begin
        map_we         = 1'b1;
        map_waddr      = tgt_r;
        map_wdata      = '{ever: 1'b1, in_use: 1'b1};
        scan_start_nxt = tgt_r;
        if (!tgt_ent_r.in_use) begin
          use_cnt_nxt = use_cnt_r + CNT_W'(1);
        end
        if (!tgt_ent_r.ever) begin
          ever_cnt_nxt = ever_cnt_r + CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_id_nxt    = tgt_r;
        out_ok_nxt    = 1'b1;
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= idab_pkg::ST_IDLE;
      min_r        <= idab_pkg::MIN_ID_RST;
      max_r        <= idab_pkg::MAX_ID_RST;
      scan_start_r <= idab_pkg::MIN_ID_RST;
      ever_cnt_r   <= '0;
      use_cnt_r    <= '0;
      q_vld_r      <= 1'b0;
      found_free_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      scan_start_r <= scan_start_nxt;
      ever_cnt_r   <= ever_cnt_nxt;
      use_cnt_r    <= use_cnt_nxt;
      q_vld_r      <= q_vld_nxt;
      found_free_r <= found_free_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        unique case (idab_pkg::cfg_idx_t'(cfg_index))
          idab_pkg::CFG_MIN_ID: min_r <= cfg_wdata;
          idab_pkg::CFG_MAX_ID: max_r <= cfg_wdata;
          default:              min_r <= min_r;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    p_r        <= p_nxt;
    cnt_r      <= cnt_nxt;
    span_r     <= span_nxt;
    q_addr_r   <= q_addr_nxt;
    free_id_r  <= free_id_nxt;
    free_ent_r <= free_ent_nxt;
    tgt_r      <= tgt_nxt;
    tgt_ent_r  <= tgt_ent_nxt;
    out_id_r   <= out_id_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_given_id = out_id_r;
  assign out_ok       = out_ok_r;

  // every id in use was also marked ever used
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    use_cnt_r <= ever_cnt_r)
    else $error("in-use count above ever-used count");

  // a result only follows an accepted item or work in flight
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(acc || (state_r != idab_pkg::ST_IDLE)))
    else $error("result without a command");

  // a handed-out id lies inside the configured range
  a_given_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_id_r != '0)) |-> ((out_id_r >= min_r) && (out_id_r <= max_r)))
    else $error("given id outside range");

  // the scan never issues more reads than the range holds
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == idab_pkg::ST_SCAN) |-> (cnt_r <= span_r))
    else $error("scan count past span");

endmodule
